>>> design/fce_pkg.sv
// ----------------------------------------------------------------------------
// fce_pkg
// Shared constants, types and saturation helpers for the feedback comb echo.
// ----------------------------------------------------------------------------
package fce_pkg;

    localparam int MAX_DELAY  = 16384;
    localparam int POS_W      = $clog2(MAX_DELAY);
    localparam int HIST_AW    = POS_W + 1;
    localparam int HIST_DEPTH = 2 * MAX_DELAY;

    localparam int DRY_W  = 16;
    localparam int WET_W  = 24;
    localparam int HIST_W = DRY_W + WET_W;
    localparam int GAIN_W = 15;
    localparam int FRAC_W = 14;
    localparam int PROD_W = WET_W + GAIN_W + 1;
    localparam int SHR_W  = PROD_W - FRAC_W;
    localparam int SUM_W  = SHR_W + 1;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_ECHO_GAIN     = 2'd0;
    localparam logic [1:0] REG_FEEDBACK_GAIN = 2'd1;
    localparam logic [1:0] REG_DELAY         = 2'd2;
    localparam logic [1:0] REG_STEREO        = 2'd3;

    localparam logic [GAIN_W-1:0] ECHO_GAIN_RST     = GAIN_W'(2949);
    localparam logic [GAIN_W-1:0] FEEDBACK_GAIN_RST = GAIN_W'(8225);
    localparam logic [POS_W-1:0]  DELAY_RST         = POS_W'(9120);

    typedef struct packed {
        logic               en;
        logic [HIST_AW-1:0] addr;
        logic [HIST_W-1:0]  data;
    } t_mem_wr;

    // Clamp a wide sum to the signed range of the wet history.
    function automatic logic [WET_W-1:0] sat_wet(input logic [SUM_W-1:0] v);
        logic [WET_W-1:0] r;
        if (!v[SUM_W-1] && (|v[SUM_W-2:WET_W-1])) begin
            r = {1'b0, {(WET_W-1){1'b1}}};
        end else if (v[SUM_W-1] && !(&v[SUM_W-2:WET_W-1])) begin
            r = {1'b1, {(WET_W-1){1'b0}}};
        end else begin
            r = v[WET_W-1:0];
        end
        return r;
    endfunction

    // Clamp a wide sum to the signed 16-bit sample range.
    function automatic logic [DRY_W-1:0] sat_dry(input logic [SUM_W-1:0] v);
        logic [DRY_W-1:0] r;
        if (!v[SUM_W-1] && (|v[SUM_W-2:DRY_W-1])) begin
            r = {1'b0, {(DRY_W-1){1'b1}}};
        end else if (v[SUM_W-1] && !(&v[SUM_W-2:DRY_W-1])) begin
            r = {1'b1, {(DRY_W-1){1'b0}}};
        end else begin
            r = v[DRY_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> design/fce_hist_mem.sv
// ----------------------------------------------------------------------------
// fce_hist_mem
// Delay history store: dry and wet samples of both lines, one write port and
// one registered read port.
// ----------------------------------------------------------------------------
module fce_hist_mem
    import fce_pkg::*;
(
    input  logic               i_clk,
    input  t_mem_wr            i_wr,
    input  logic               i_rd_en,
    input  logic [HIST_AW-1:0] i_rd_addr,
    output logic [HIST_W-1:0]  o_rd_data
);

    logic [HIST_W-1:0] r_mem [HIST_DEPTH];
    logic [HIST_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/fce_mul.sv
// ----------------------------------------------------------------------------
// fce_mul
// Shared registered multiplier: signed wet value times unsigned Q1.14 gain.
// ----------------------------------------------------------------------------
module fce_mul
    import fce_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [GAIN_W-1:0] i_gain,
    input  logic [WET_W-1:0]  i_operand,
    output logic [PROD_W-1:0] o_product
);

    logic signed [PROD_W-1:0] r_product;
    logic signed [GAIN_W:0]   w_gain_s;
    logic signed [WET_W-1:0]  w_op_s;

    assign w_gain_s = $signed({1'b0, i_gain});
    assign w_op_s   = $signed(i_operand);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_product <= PROD_W'(w_op_s) * PROD_W'(w_gain_s);
        end
    end

    assign o_product = r_product;

endmodule

>>> design/feedback_comb_echo.sv
// ----------------------------------------------------------------------------
// feedback_comb_echo
// Feedback comb echo on 16-bit PCM with separate left and right delay lines.
// A request steps through S_MUL1, S_ADD1, S_MUL2 and S_FIN; the result is
// registered once S_FIN finds the output free. Samples enter only in S_IDLE or
// S_FIN; the shared multiplier serves the feedback, then the wet product.
// Reset clears registers to their defaults and both write positions; history
// that was never written reads as zero through a per-line wrap flag.
// ----------------------------------------------------------------------------
module feedback_comb_echo
    import fce_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [DRY_W-1:0]  i_sample,
    input  logic              i_channel,
    input  logic              i_frame_last,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DRY_W-1:0]  o_out_sample,
    output logic              o_out_channel,
    output logic              o_out_last,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    typedef enum logic [2:0] {S_IDLE, S_MUL1, S_ADD1, S_MUL2, S_FIN} t_state;

    t_state r_state;

    logic [GAIN_W-1:0] r_echo_gain;
    logic [GAIN_W-1:0] r_fb_gain;
    logic [POS_W-1:0]  r_delay;
    logic              r_stereo;

    logic [POS_W-1:0]  r_pos [2];
    logic [1:0]        r_wrap;

    logic [DRY_W-1:0]  r_x;
    logic              r_chan;
    logic              r_last;
    logic              r_side;
    logic              r_hist_ok;
    logic [WET_W-1:0]  r_y;

    logic              r_o_valid;
    logic [DRY_W-1:0]  r_o_sample;
    logic              r_o_chan;
    logic              r_o_last;

    logic              w_out_free;
    logic              w_accept;
    logic              w_side;
    logic [POS_W-1:0]  w_pos;
    logic [POS_W-1:0]  w_dly;
    logic [POS_W-1:0]  w_rd;
    logic              w_rd_ok;
    logic [1:0]        w_reg_idx;
    logic              w_cfg_wr;

    logic [HIST_W-1:0] w_hist;
    logic [DRY_W-1:0]  w_xd;
    logic [WET_W-1:0]  w_yd;

    logic              w_mul_en;
    logic [GAIN_W-1:0] w_mul_gain;
    logic [WET_W-1:0]  w_mul_op;
    logic [PROD_W-1:0] w_prod;
    logic [SUM_W-1:0]  w_sum1;
    logic [SUM_W-1:0]  w_sum2;
    logic [WET_W-1:0]  w_y;
    logic [DRY_W-1:0]  w_o;

    t_mem_wr           w_wr;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_gain <= ECHO_GAIN_RST;
            r_fb_gain   <= FEEDBACK_GAIN_RST;
            r_delay     <= DELAY_RST;
            r_stereo    <= 1'b0;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_ECHO_GAIN:     r_echo_gain <= pwdata[GAIN_W-1:0];
                REG_FEEDBACK_GAIN: r_fb_gain   <= pwdata[GAIN_W-1:0];
                REG_DELAY:         r_delay     <= pwdata[POS_W-1:0];
                REG_STEREO:        r_stereo    <= pwdata[0];
                default:           r_stereo    <= r_stereo;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_ECHO_GAIN:     prdata = {{(APB_DW-GAIN_W){1'b0}}, r_echo_gain};
            REG_FEEDBACK_GAIN: prdata = {{(APB_DW-GAIN_W){1'b0}}, r_fb_gain};
            REG_DELAY:         prdata = {{(APB_DW-POS_W){1'b0}}, r_delay};
            REG_STEREO:        prdata = {{(APB_DW-1){1'b0}}, r_stereo};
            default:           prdata = '0;
        endcase
    end

    // ---------------- request side and read address ----------------
    assign w_out_free = !r_o_valid || i_ready;
    assign o_ready    = (r_state == S_IDLE) || ((r_state == S_FIN) && w_out_free);
    assign w_accept   = i_valid && o_ready;

    assign w_side = r_stereo & i_channel;
    assign w_pos  = r_pos[w_side];
    assign w_dly  = (r_delay == '0) ? POS_W'(1) : r_delay;
    assign w_rd   = w_pos - w_dly;
    // Before a line first wraps, only entries below its write position exist.
    assign w_rd_ok = r_wrap[w_side] || (w_rd < w_pos);

    fce_hist_mem u_hist (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_en   (w_accept),
        .i_rd_addr ({w_side, w_rd}),
        .o_rd_data (w_hist)
    );

    assign w_xd = r_hist_ok ? w_hist[HIST_W-1:WET_W] : '0;
    assign w_yd = r_hist_ok ? w_hist[WET_W-1:0] : '0;

    // ---------------- shared multiplier ----------------
    assign w_mul_en   = (r_state == S_MUL1) || (r_state == S_MUL2);
    assign w_mul_gain = (r_state == S_MUL2) ? r_echo_gain : r_fb_gain;
    assign w_mul_op   = (r_state == S_MUL2) ? r_y : w_yd;

    fce_mul u_mul (
        .i_clk     (i_clk),
        .i_en      (w_mul_en),
        .i_gain    (w_mul_gain),
        .i_operand (w_mul_op),
        .o_product (w_prod)
    );

    assign w_sum1 = SUM_W'($signed(w_prod[PROD_W-1:FRAC_W])) + SUM_W'($signed(w_xd));
    assign w_sum2 = SUM_W'($signed(w_prod[PROD_W-1:FRAC_W])) + SUM_W'($signed(r_x));
    assign w_y    = sat_wet(w_sum1);
    assign w_o    = sat_dry(w_sum2);

    always_comb begin
        w_wr.en   = (r_state == S_ADD1);
        w_wr.addr = {r_side, r_pos[r_side]};
        w_wr.data = {r_x, w_y};
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos[0]  <= '0;
            r_pos[1]  <= '0;
            r_wrap    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if ((r_state == S_FIN) && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_state <= S_ADD1;
                end
                S_ADD1: begin
                    r_y           <= w_y;
                    r_pos[r_side] <= r_pos[r_side] + POS_W'(1);
                    if (&r_pos[r_side]) begin
                        r_wrap[r_side] <= 1'b1;
                    end
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_o_sample <= w_o;
                        r_o_chan   <= r_chan;
                        r_o_last   <= r_last;
                        r_state    <= w_accept ? S_MUL1 : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_accept) begin
                r_x       <= i_sample;
                r_chan    <= i_channel;
                r_last    <= i_frame_last;
                r_side    <= w_side;
                r_hist_ok <= w_rd_ok;
            end
        end
    end

    assign o_valid       = r_o_valid;
    assign o_out_sample  = r_o_sample;
    assign o_out_channel = r_o_chan;
    assign o_out_last    = r_o_last;

endmodule
